[sv/fpfa_pkg.sv]
`default_nettype none
package fpfa_pkg;

	localparam int MAX_PARTITIONS_DEF = 16;
	localparam int SIZE_WIDTH_DEF = 16;

	localparam int FIELD_SIZE_W = 16;
	localparam int TOTAL_W = 20;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 5;

	// opcode codes of an input item
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_POLICY = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NF_START = 2'd2;

	localparam logic [4:0] COUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		POL_BEST = 2'd0,
		POL_WORST = 2'd1,
		POL_FIRST = 2'd2,
		POL_NEXT = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		K_LOAD,
		K_ALLOC,
		K_CLEAR,
		K_NOP
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FINISH
	} back_state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] slot_index;
		logic [FIELD_SIZE_W-1:0] slot_size;
		logic [FIELD_SIZE_W-1:0] request_size;
	} in_item_t;

	typedef struct packed {
		logic granted;
		logic [4:0] partition_number;
		logic [FIELD_SIZE_W-1:0] granted_size;
		logic [FIELD_SIZE_W-1:0] internal_fragment;
		logic [TOTAL_W-1:0] total_fragment;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [3:0] slot_index;
		logic [FIELD_SIZE_W-1:0] slot_size;
		logic [FIELD_SIZE_W-1:0] request_size;
	} cmd_t;

	typedef struct packed {
		policy_t policy;
		logic [4:0] count;
		logic [3:0] nf_start;
	} cfg_t;

endpackage
`default_nettype wire

[sv/fixed_partition_fit_allocator.sv]
// an allocate gives its result after a scan of the n partitions in use (one read a cycle);
// every other item, and an allocate with n = 0, gives its result without a scan
// throughput: one load or clear per cycle when the executor is free; an allocate holds it
// through its scan, and a two-entry command queue keeps taking items meanwhile (busy when full)
// reset: registers to defaults, used marks, total and next-fit pointer cleared;
// the size table is not cleared. results cannot be stalled
`default_nettype none
module fixed_partition_fit_allocator #(
	parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
	parameter int SIZE_WIDTH = fpfa_pkg::SIZE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire fpfa_pkg::in_item_t request,
	output logic done,
	output fpfa_pkg::out_item_t result,
	input wire logic cfg_we,
	input wire logic [fpfa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [fpfa_pkg::CFG_DATA_W-1:0] cfg_data
);

	fpfa_pkg::cfg_t cfg_q;
	logic cmd_valid;
	logic cmd_ready;
	fpfa_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy <= fpfa_pkg::POL_BEST;
			cfg_q.count <= fpfa_pkg::COUNT_RESET;
			cfg_q.nf_start <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpfa_pkg::REG_POLICY: cfg_q.policy <= fpfa_pkg::policy_t'(cfg_data[1:0]);
				fpfa_pkg::REG_COUNT: cfg_q.count <= cfg_data;
				fpfa_pkg::REG_NF_START: cfg_q.nf_start <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	fpfa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_ready(cmd_ready)
	);

	fpfa_back #(
		.MAX_PARTITIONS(MAX_PARTITIONS),
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_ready(cmd_ready),
		.done(done),
		.result(result)
	);

endmodule
`default_nettype wire

[sv/fpfa_front.sv]
`default_nettype none
module fpfa_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire fpfa_pkg::in_item_t request,
	output logic busy,
	output logic cmd_valid,
	output fpfa_pkg::cmd_t cmd,
	input wire logic cmd_ready
);

	fpfa_pkg::cmd_t queue_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	fpfa_pkg::cmd_t classified;
	logic push;
	logic pop;

	always_comb begin
		classified.slot_index = request.slot_index;
		classified.slot_size = request.slot_size;
		classified.request_size = request.request_size;
		unique case (request.opcode)
			fpfa_pkg::OP_LOAD: classified.kind = fpfa_pkg::K_LOAD;
			fpfa_pkg::OP_ALLOC: classified.kind = fpfa_pkg::K_ALLOC;
			fpfa_pkg::OP_CLEAR: classified.kind = fpfa_pkg::K_CLEAR;
			default: classified.kind = fpfa_pkg::K_NOP;
		endcase
	end

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= classified;
	end

endmodule
`default_nettype wire

[sv/fpfa_back.sv]
`default_nettype none
module fpfa_back #(
	parameter int MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
	parameter int SIZE_WIDTH = fpfa_pkg::SIZE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire fpfa_pkg::cfg_t cfg,
	input wire logic cmd_valid,
	input wire fpfa_pkg::cmd_t cmd,
	output logic cmd_ready,
	output logic done,
	output fpfa_pkg::out_item_t result
);

	localparam int PW = $clog2(MAX_PARTITIONS);
	localparam int NW = $clog2(MAX_PARTITIONS + 1);
	localparam int SPW = (PW > 4) ? PW : 4;
	localparam int CW = (SIZE_WIDTH > fpfa_pkg::FIELD_SIZE_W) ?
		SIZE_WIDTH : fpfa_pkg::FIELD_SIZE_W;
	localparam int SW = ((CW > fpfa_pkg::TOTAL_W) ? CW : fpfa_pkg::TOTAL_W) + 1;

	fpfa_pkg::back_state_t state_q;
	fpfa_pkg::back_state_t state_d;

	logic [SIZE_WIDTH-1:0] mem [MAX_PARTITIONS];
	logic [MAX_PARTITIONS-1:0] used_q;
	logic [SPW-1:0] ptr_q;
	logic [fpfa_pkg::TOTAL_W-1:0] total_q;
	logic done_q;
	fpfa_pkg::out_item_t result_q;

	logic [NW-1:0] n_active;
	logic [NW-1:0] n_q;
	logic [NW-1:0] iss_cnt_q;
	logic [PW-1:0] iss_idx_q;
	logic [NW-1:0] iss_idx_inc;
	logic last_issue;
	logic [PW-1:0] scan_start;
	logic [fpfa_pkg::FIELD_SIZE_W-1:0] req_q;

	logic vld_s1;
	logic used_s1;
	logic [PW-1:0] idx_s1;
	logic [SIZE_WIDTH-1:0] size_s1;

	logic found_q;
	logic [PW-1:0] best_idx_q;
	logic [SIZE_WIDTH-1:0] best_size_q;

	logic fit;
	logic take;
	logic start_alloc;
	logic load_we;
	logic [CW-1:0] frag;
	logic [SW-1:0] sum;
	logic [fpfa_pkg::TOTAL_W-1:0] total_next;

	assign n_active = (32'(cfg.count) > MAX_PARTITIONS) ?
		NW'(MAX_PARTITIONS) : NW'(cfg.count);
	assign scan_start = (cfg.policy == fpfa_pkg::POL_NEXT && 32'(ptr_q) < 32'(n_active)) ?
		PW'(ptr_q) : '0;
	assign iss_idx_inc = NW'(iss_idx_q) + NW'(1);
	assign last_issue = (iss_cnt_q == n_q - NW'(1));

	assign start_alloc = (state_q == fpfa_pkg::ST_IDLE) && cmd_valid &&
		cmd.kind == fpfa_pkg::K_ALLOC && n_active != '0;
	assign load_we = (state_q == fpfa_pkg::ST_IDLE) && cmd_valid &&
		cmd.kind == fpfa_pkg::K_LOAD && 32'(cmd.slot_index) < MAX_PARTITIONS;

	// best and worst replace only on a strict improvement, so the lowest index wins ties
	always_comb begin
		fit = !used_s1 && CW'(size_s1) >= CW'(req_q);
		take = fit && (!found_q ||
			(cfg.policy == fpfa_pkg::POL_BEST && size_s1 < best_size_q) ||
			(cfg.policy == fpfa_pkg::POL_WORST && size_s1 > best_size_q));
	end

	assign frag = CW'(best_size_q) - CW'(req_q);
	assign sum = SW'(total_q) + SW'(frag);
	assign total_next = (sum > SW'(fpfa_pkg::TOTAL_MAX)) ?
		fpfa_pkg::TOTAL_MAX : fpfa_pkg::TOTAL_W'(sum);

	always_comb begin
		state_d = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			fpfa_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_ready = 1'b1;
					if (start_alloc) state_d = fpfa_pkg::ST_SCAN;
				end
			end
			fpfa_pkg::ST_SCAN: begin
				if (last_issue) state_d = fpfa_pkg::ST_WAIT;
			end
			fpfa_pkg::ST_WAIT: state_d = fpfa_pkg::ST_FINISH;
			fpfa_pkg::ST_FINISH: state_d = fpfa_pkg::ST_IDLE;
			default: state_d = fpfa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fpfa_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// size table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (load_we) mem[PW'(cmd.slot_index)] <= SIZE_WIDTH'(cmd.slot_size);
		size_s1 <= mem[iss_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ptr_q <= '0;
			total_q <= '0;
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == fpfa_pkg::ST_SCAN);
			if (vld_s1 && take) found_q <= 1'b1;
			unique case (state_q)
				fpfa_pkg::ST_IDLE: begin
					found_q <= 1'b0;
					if (cmd_valid && !start_alloc) done_q <= 1'b1;
					if (cmd_valid && cmd.kind == fpfa_pkg::K_CLEAR) begin
						used_q <= '0;
						total_q <= '0;
						ptr_q <= SPW'(cfg.nf_start);
					end
				end
				fpfa_pkg::ST_FINISH: begin
					done_q <= 1'b1;
					if (found_q) begin
						used_q[best_idx_q] <= 1'b1;
						total_q <= total_next;
						if (cfg.policy == fpfa_pkg::POL_NEXT) ptr_q <= SPW'(best_idx_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		used_s1 <= used_q[iss_idx_q];
		idx_s1 <= iss_idx_q;
		if (vld_s1 && take) begin
			best_idx_q <= idx_s1;
			best_size_q <= size_s1;
		end
		if (start_alloc) begin
			n_q <= n_active;
			iss_cnt_q <= '0;
			iss_idx_q <= scan_start;
			req_q <= cmd.request_size;
		end else if (state_q == fpfa_pkg::ST_SCAN) begin
			iss_cnt_q <= iss_cnt_q + NW'(1);
			// wrap around for a round-robin scan
			iss_idx_q <= (iss_idx_inc >= n_q) ? '0 : PW'(iss_idx_inc);
		end
		if (state_q == fpfa_pkg::ST_IDLE) begin
			result_q.granted <= 1'b0;
			result_q.partition_number <= '0;
			result_q.granted_size <= '0;
			result_q.internal_fragment <= '0;
			result_q.total_fragment <= (cmd.kind == fpfa_pkg::K_CLEAR) ? '0 : total_q;
		end else if (state_q == fpfa_pkg::ST_FINISH) begin
			result_q.granted <= found_q;
			result_q.partition_number <= found_q ? 5'(32'(best_idx_q) + 1) : '0;
			result_q.granted_size <= found_q ?
				fpfa_pkg::FIELD_SIZE_W'(best_size_q) : '0;
			result_q.internal_fragment <= found_q ? fpfa_pkg::FIELD_SIZE_W'(frag) : '0;
			result_q.total_fragment <= found_q ? total_next : total_q;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire
